// ----- src/sls_pkg.sv -----
// ----------------------------------------------------------------------------
// sls_pkg: shared definitions for the line stepper
// Types, codes and reset values used by the line stepper modules.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int COORD_BITS_DEF = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] HALF_WIDTH_RST  = 10'd400;
    localparam logic [CFG_DATA_W-1:0] HALF_HEIGHT_RST = 10'd300;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] half_width;
        logic [CFG_DATA_W-1:0] half_height;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_HORIZ = 2'd0,
        KIND_VERT  = 2'd1,
        KIND_SLOPE = 2'd2
    } t_kind;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_STEP = 7'b0000100,
        S_ABS  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

endpackage

// ----- src/sls_if.sv -----
// ----------------------------------------------------------------------------
// sls_if: channel interfaces of the line stepper
// Endpoint input channel, pixel output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sls_pt_if #(
    parameter int CB = sls_pkg::COORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] bx;
    logic signed [CB-1:0] by;

    modport source (output valid, mode, ax, ay, bx, by, input ready);
    modport sink   (input valid, mode, ax, ay, bx, by, output ready);
endinterface

interface sls_px_if #(
    parameter int CB = sls_pkg::COORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] px;
    logic signed [CB:0]   py;
    logic signed [CB+1:0] screen_x;
    logic signed [CB+1:0] screen_y;
    logic                 last;

    modport source (output valid, px, py, screen_x, screen_y, last, input ready);
    modport sink   (input valid, px, py, screen_x, screen_y, last, output ready);
endinterface

interface sls_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sls_pkg::CFG_IDX_W-1:0]   index;
    logic [sls_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/sls_alu.sv -----
// ----------------------------------------------------------------------------
// sls_alu: shared add/subtract unit
// The one adder used by the sequencer for multiply, step and divide work.
// ----------------------------------------------------------------------------
module sls_alu #(
    parameter int W = 2 * sls_pkg::COORD_BITS_DEF + 3
) (
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  sls_pkg::t_alu_op i_op,
    output logic [W-1:0]     o_y
);

    always_comb begin
        case (i_op)
            sls_pkg::ALU_ADD: o_y = i_a + i_b;
            sls_pkg::ALU_SUB: o_y = i_a - i_b;
            default:          o_y = i_a + i_b;
        endcase
    end

endmodule

// ----- src/sls_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sls_cfg_regs: configuration registers
// Holds half width and half height; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sls_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sls_cfg_if.sink       i_cfg,
    output sls_pkg::t_cfg o_cfg
);

    sls_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width  <= sls_pkg::HALF_WIDTH_RST;
            r_cfg.half_height <= sls_pkg::HALF_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sls_pkg::CFG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg.data;
                sls_pkg::CFG_HALF_HEIGHT: r_cfg.half_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/slope_intercept_line_stepper_core.sv -----
// ----------------------------------------------------------------------------
// slope_intercept_line_stepper_core: slope-intercept line rasterizer
// Starts a line from two endpoints and emits one pixel per advance request.
// ----------------------------------------------------------------------------
// A mode-0 transaction loads two endpoints, orders them so x rises and emits
// the first pixel; each mode-1 transaction emits the next pixel, and one with
// no active line gives nothing. Horizontal and vertical pixels pass from
// acceptance through S_OUT to the output register. Sloped lines keep a running
// numerator N = 2*(by*dx + dy*(x-bx)) + dx, which starts as dx*(2*ay+1) and
// grows by 2*dy per pixel; y is N / (2*dx) truncated toward zero. All of that
// runs on one shared adder: the start multiply is shift-add in S_MUL and the
// divide is restoring in S_DIV, one quotient bit a cycle. A first sloped
// pixel passes S_MUL, S_ABS, S_DIV, S_FIX and S_OUT; each later one passes
// S_STEP, S_ABS, S_DIV, S_FIX and S_OUT.
// The input is ready only while the sequencer idles; a pixel waiting in the
// output register does not block the next transaction, only the next write.
// ----------------------------------------------------------------------------
module slope_intercept_line_stepper_core #(
    parameter int COORD_BITS = sls_pkg::COORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sls_pt_if.sink   i_pt,
    sls_px_if.source o_pix,
    sls_cfg_if.sink  i_cfg
);

    localparam int CB    = COORD_BITS;
    // numerator and remainder width, covers |N| < 2^(2*CB+2) plus sign
    localparam int NUM_W = 2 * CB + 3;
    localparam int CNT_W = $clog2(CB + 2);

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    sls_pkg::t_cfg cfg;

    sls_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------------
    sls_pkg::t_state r_state, n_state;
    logic            r_active, n_active;
    sls_pkg::t_kind  r_kind, n_kind;

    logic signed [CB-1:0]  r_cur, n_cur;       // stepped coordinate
    logic signed [CB-1:0]  r_end, n_end;
    logic signed [CB-1:0]  r_fixed, n_fixed;
    logic        [CB-1:0]  r_dx, n_dx;         // bx-ax, never negative
    logic signed [CB:0]    r_dy, n_dy;
    logic        [NUM_W-1:0] r_num, n_num;     // running numerator
    logic        [NUM_W-1:0] r_acc, n_acc;     // product / remainder
    logic        [NUM_W-1:0] r_opnd, n_opnd;   // shifted multiplicand / divisor
    logic        [CB-1:0]  r_mbits, n_mbits;   // multiplier bits still to use
    logic        [CNT_W-1:0] r_cnt, n_cnt;
    logic        [CB:0]    r_q, n_q;           // quotient magnitude
    logic                  r_neg, n_neg;
    logic signed [CB:0]    r_y, n_y;           // sloped y result

    // output register
    logic                  r_ov, n_ov;
    logic signed [CB-1:0]  r_px, n_px;
    logic signed [CB:0]    r_py, n_py;
    logic signed [CB+1:0]  r_sx, n_sx;
    logic signed [CB+1:0]  r_sy, n_sy;
    logic                  r_last, n_last;

    // ------------------------------------------------------------------------
    // shared adder
    // ------------------------------------------------------------------------
    logic [NUM_W-1:0]  alu_a, alu_b, alu_y;
    sls_pkg::t_alu_op  alu_op;

    sls_alu #(.W(NUM_W)) u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_y  (alu_y)
    );

    // ------------------------------------------------------------------------
    // endpoint ordering for a new line
    // ------------------------------------------------------------------------
    logic                 swap;
    logic signed [CB-1:0] sw_ax, sw_ay, sw_bx, sw_by;
    logic signed [CB-1:0] y_lo, y_hi;
    logic signed [CB:0]   dx_full, dy_full;
    logic signed [CB:0]   m_start;             // 2*ay+1
    logic signed [CB+1:0] dy2;
    logic                 pt_acc;

    assign pt_acc = i_pt.valid && i_pt.ready;
    assign swap   = i_pt.ax > i_pt.bx;
    assign sw_ax  = swap ? i_pt.bx : i_pt.ax;
    assign sw_ay  = swap ? i_pt.by : i_pt.ay;
    assign sw_bx  = swap ? i_pt.ax : i_pt.bx;
    assign sw_by  = swap ? i_pt.ay : i_pt.by;
    assign y_lo   = (sw_ay > sw_by) ? sw_by : sw_ay;
    assign y_hi   = (sw_ay > sw_by) ? sw_ay : sw_by;

    assign dx_full = (CB+1)'(sw_bx) - (CB+1)'(sw_ax);
    assign dy_full = (CB+1)'(sw_by) - (CB+1)'(sw_ay);
    assign m_start = {sw_ay, 1'b1};
    assign dy2     = {r_dy, 1'b0};

    assign i_pt.ready = (r_state == sls_pkg::S_IDLE);

    // ------------------------------------------------------------------------
    // pixel assembly for the output register
    // ------------------------------------------------------------------------
    logic signed [CB-1:0] pix_x;
    logic signed [CB:0]   pix_y;
    logic        [CB+1:0] pix_sx, pix_sy;

    always_comb begin
        case (r_kind)
            sls_pkg::KIND_HORIZ: begin
                pix_x = r_cur;
                pix_y = (CB+1)'(r_fixed);
            end
            sls_pkg::KIND_VERT: begin
                pix_x = r_fixed;
                pix_y = (CB+1)'(r_cur);
            end
            default: begin
                pix_x = r_cur;
                pix_y = r_y;
            end
        endcase
        pix_sx = (CB+2)'(pix_x) + (CB+2)'(cfg.half_width);
        pix_sy = (CB+2)'(cfg.half_height) - (CB+2)'(pix_y);
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    logic trial_ok;
    assign trial_ok = !alu_y[NUM_W-1];

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_kind   = r_kind;
        n_cur    = r_cur;
        n_end    = r_end;
        n_fixed  = r_fixed;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_num    = r_num;
        n_acc    = r_acc;
        n_opnd   = r_opnd;
        n_mbits  = r_mbits;
        n_cnt    = r_cnt;
        n_q      = r_q;
        n_neg    = r_neg;
        n_y      = r_y;
        n_ov     = r_ov && !o_pix.ready;
        n_px     = r_px;
        n_py     = r_py;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_last   = r_last;

        alu_a  = r_acc;
        alu_b  = r_opnd;
        alu_op = sls_pkg::ALU_ADD;

        case (r_state)
            sls_pkg::S_IDLE: begin
                if (pt_acc && !i_pt.mode) begin
                    n_cur = sw_ax;
                    n_end = sw_bx;
                    if (sw_ay == sw_by) begin
                        n_kind   = sls_pkg::KIND_HORIZ;
                        n_fixed  = sw_ay;
                        n_state  = sls_pkg::S_OUT;
                    end else if (sw_ax == sw_bx) begin
                        n_kind   = sls_pkg::KIND_VERT;
                        n_cur    = y_lo;
                        n_end    = y_hi;
                        n_fixed  = sw_ax;
                        n_state  = sls_pkg::S_OUT;
                    end else begin
                        n_kind   = sls_pkg::KIND_SLOPE;
                        n_dx     = dx_full[CB-1:0];
                        n_dy     = dy_full;
                        n_acc    = '0;
                        n_opnd   = NUM_W'(m_start);
                        n_mbits  = dx_full[CB-1:0];
                        n_cnt    = CNT_W'(CB);
                        n_state  = sls_pkg::S_MUL;
                    end
                end else if (pt_acc && r_active) begin
                    n_cur   = r_cur + CB'(1);
                    n_state = (r_kind == sls_pkg::KIND_SLOPE) ? sls_pkg::S_STEP
                                                              : sls_pkg::S_OUT;
                end
            end

            // N = dx * (2*ay+1), one multiplier bit a cycle
            sls_pkg::S_MUL: begin
                alu_a  = r_acc;
                alu_b  = r_mbits[0] ? r_opnd : '0;
                alu_op = sls_pkg::ALU_ADD;
                n_acc   = alu_y;
                n_opnd  = r_opnd << 1;
                n_mbits = r_mbits >> 1;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_num   = alu_y;
                    n_state = sls_pkg::S_ABS;
                end
            end

            // next x: N += 2*dy
            sls_pkg::S_STEP: begin
                alu_a   = r_num;
                alu_b   = NUM_W'(dy2);
                alu_op  = sls_pkg::ALU_ADD;
                n_num   = alu_y;
                n_state = sls_pkg::S_ABS;
            end

            // remainder = |N|, divisor = 2*dx aligned to the top quotient bit
            sls_pkg::S_ABS: begin
                alu_a   = '0;
                alu_b   = r_num;
                alu_op  = sls_pkg::ALU_SUB;
                n_neg   = r_num[NUM_W-1];
                n_acc   = r_num[NUM_W-1] ? alu_y : r_num;
                n_opnd  = NUM_W'(r_dx) << (CB + 1);
                n_q     = '0;
                n_cnt   = CNT_W'(CB + 1);
                n_state = sls_pkg::S_DIV;
            end

            sls_pkg::S_DIV: begin
                alu_a  = r_acc;
                alu_b  = r_opnd;
                alu_op = sls_pkg::ALU_SUB;
                if (trial_ok) begin
                    n_acc = alu_y;
                end
                n_q    = {r_q[CB-1:0], trial_ok};
                n_opnd = r_opnd >> 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = sls_pkg::S_FIX;
                end
            end

            // restore the sign: truncation toward zero
            sls_pkg::S_FIX: begin
                alu_a   = '0;
                alu_b   = NUM_W'(r_q);
                alu_op  = sls_pkg::ALU_SUB;
                n_y     = r_neg ? alu_y[CB:0] : r_q;
                n_state = sls_pkg::S_OUT;
            end

            // wait for the output register to free up
            sls_pkg::S_OUT: begin
                if (!r_ov || o_pix.ready) begin
                    n_ov     = 1'b1;
                    n_px     = pix_x;
                    n_py     = pix_y;
                    n_sx     = pix_sx;
                    n_sy     = pix_sy;
                    n_last   = (r_cur == r_end);
                    n_active = (r_cur != r_end);
                    n_state  = sls_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sls_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sls_pkg::S_IDLE;
            r_active <= 1'b0;
            r_kind   <= sls_pkg::KIND_HORIZ;
            r_ov     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_kind   <= n_kind;
            r_ov     <= n_ov;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_end   <= n_end;
        r_fixed <= n_fixed;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_num   <= n_num;
        r_acc   <= n_acc;
        r_opnd  <= n_opnd;
        r_mbits <= n_mbits;
        r_q     <= n_q;
        r_neg   <= n_neg;
        r_y     <= n_y;
        r_px    <= n_px;
        r_py    <= n_py;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_last  <= n_last;
    end

    assign o_pix.valid    = r_ov;
    assign o_pix.px       = r_px;
    assign o_pix.py       = r_py;
    assign o_pix.screen_x = r_sx;
    assign o_pix.screen_y = r_sy;
    assign o_pix.last     = r_last;

endmodule
